>>> src/rbdd_pkg.sv
// shared types and constants for the block delta decompressor
`default_nettype none

package rbdd_pkg;

    localparam int BLOCK_PIXELS  = 16;
    localparam int MAX_ROW_WIDTH = 16384;
    localparam int QUEUE_DEPTH   = 2;

    localparam int PIX_W    = 11;
    localparam int POS_W    = 14;
    localparam int WIDTH_W  = 15;
    localparam int IDX_W    = 4;
    localparam int SH_W     = 3;
    localparam int DELTA_W  = 7;
    // delta field spans bits 127:30 of the block
    localparam int DELTA_LO   = 30;
    localparam int DELTA_SPAN = 128 - DELTA_LO;

    localparam logic [WIDTH_W-1:0] ROW_WIDTH_RESET = 15'd4096;
    localparam logic [WIDTH_W-1:0] ROW_WIDTH_MAX   = WIDTH_W'(MAX_ROW_WIDTH);
    localparam logic [PIX_W-1:0]   PIX_MAX         = 11'h7FF;
    localparam logic [IDX_W-1:0]   LAST_PIXEL      = IDX_W'(BLOCK_PIXELS - 1);

    typedef struct packed {
        logic [63:0] block_high;
        logic [63:0] block_low;
    } in_word_t;

    typedef struct packed {
        logic [PIX_W-1:0] pixel_value;
        logic [POS_W-1:0] pixel_column;
        logic [POS_W-1:0] pixel_row;
        logic             block_done;
    } out_word_t;

    // classified block handed from front to back
    typedef struct packed {
        logic [DELTA_SPAN-1:0] deltas;
        logic [PIX_W-1:0]      max_val;
        logic [PIX_W-1:0]      min_val;
        logic [IDX_W-1:0]      max_idx;
        logic [IDX_W-1:0]      min_idx;
        logic [SH_W-1:0]       shift;
        logic [POS_W-1:0]      column_base;
        logic [POS_W-1:0]      row_index;
    } job_t;

endpackage

`default_nettype wire

>>> src/rbdd_front.sv
// front end: unpacks block header, picks shift, tracks column and row
`default_nettype none

module rbdd_front
    import rbdd_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               cfg_wr_en,
    input  wire logic [WIDTH_W-1:0] cfg_wr_data,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire in_word_t           s_word,
    output logic                    push,
    input  wire logic               q_ready,
    output job_t                    job
);

    logic [WIDTH_W-1:0] row_width_reg;
    logic [POS_W-1:0]   column_base_reg, column_base_next;
    logic [POS_W-1:0]   row_index_reg, row_index_next;

    logic [127:0]       blk;
    logic [PIX_W-1:0]   mx, mn, range_val;
    logic [SH_W-1:0]    sh;
    logic [WIDTH_W-1:0] w_eff, col_adv, col_test;

    assign s_ready = q_ready;
    assign push    = s_valid && q_ready;

    // header fields
    assign blk = {s_word.block_high, s_word.block_low};
    assign mx  = blk[10:0];
    assign mn  = blk[21:11];
    assign range_val = mx - mn;

    // smallest shift that covers max - min, capped at 4; zero when max is below min
    always_comb begin
        sh = '0;
        if (mx >= mn) begin
            if (range_val < 11'd128)       sh = 3'd0;
            else if (range_val < 11'd256)  sh = 3'd1;
            else if (range_val < 11'd512)  sh = 3'd2;
            else if (range_val < 11'd1024) sh = 3'd3;
            else                           sh = 3'd4;
        end
    end

    always_comb begin
        job.deltas      = blk[127:DELTA_LO];
        job.max_val     = mx;
        job.min_val     = mn;
        job.max_idx     = blk[25:22];
        job.min_idx     = blk[29:26];
        job.shift       = sh;
        job.column_base = column_base_reg;
        job.row_index   = row_index_reg;
    end

    // column and row advance after each block
    assign w_eff    = (row_width_reg > ROW_WIDTH_MAX) ? ROW_WIDTH_MAX : row_width_reg;
    assign col_adv  = {1'b0, column_base_reg} + (column_base_reg[0] ? 15'd31 : 15'd1);
    assign col_test = col_adv + 15'd30;

    always_comb begin
        column_base_next = column_base_reg;
        row_index_next   = row_index_reg;
        if (push) begin
            if (col_test >= w_eff) begin
                column_base_next = '0;
                row_index_next   = row_index_reg + 14'd1;
            end else begin
                column_base_next = col_adv[POS_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_width_reg   <= ROW_WIDTH_RESET;
            column_base_reg <= '0;
            row_index_reg   <= '0;
        end else begin
            if (cfg_wr_en) row_width_reg <= cfg_wr_data;
            column_base_reg <= column_base_next;
            row_index_reg   <= row_index_next;
        end
    end

endmodule

`default_nettype wire

>>> src/rbdd_queue.sv
// short register queue between front and back
`default_nettype none

module rbdd_queue
    import rbdd_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic push,
    input  wire job_t in_job,
    output logic      in_ready,
    input  wire logic pop,
    output logic      out_valid,
    output job_t      out_job
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

    job_t             entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign in_ready  = (count_reg != CNT_FULL);
    assign out_valid = (count_reg != '0);
    assign out_job   = entry_reg[rd_ptr_reg];

    // entry storage
    always_ff @(posedge aclk) begin
        if (push) entry_reg[wr_ptr_reg] <= in_job;
    end

    // pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) wr_ptr_reg <= (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
            if (pop)  rd_ptr_reg <= (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
            if (push && !pop)      count_reg <= count_reg + 1'b1;
            else if (pop && !push) count_reg <= count_reg - 1'b1;
        end
    end

endmodule

`default_nettype wire

>>> src/rbdd_back.sv
// back end: expands one block into sixteen pixel words
`default_nettype none

module rbdd_back
    import rbdd_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic q_valid,
    input  wire job_t q_job,
    output logic      pop,
    output logic      m_valid,
    input  wire logic m_ready,
    output out_word_t m_word
);

    job_t                  job_reg;
    logic [DELTA_SPAN-1:0] delta_reg;
    logic [IDX_W-1:0]      cnt_reg;
    logic                  work_valid_reg;
    out_word_t             out_reg;
    logic                  out_valid_reg;

    logic             adv, last, use_delta;
    logic [PIX_W:0]   sum;
    logic [PIX_W-1:0] pix;

    assign adv  = work_valid_reg && (!out_valid_reg || m_ready);
    assign last = (cnt_reg == LAST_PIXEL);
    assign pop  = q_valid && (!work_valid_reg || (adv && last));

    // pixel value for the current position
    assign use_delta = (cnt_reg != job_reg.max_idx) && (cnt_reg != job_reg.min_idx);
    assign sum = ({{(PIX_W + 1 - DELTA_W){1'b0}}, delta_reg[DELTA_W-1:0]} << job_reg.shift)
               + {1'b0, job_reg.min_val};

    always_comb begin
        if (cnt_reg == job_reg.max_idx)      pix = job_reg.max_val;
        else if (cnt_reg == job_reg.min_idx) pix = job_reg.min_val;
        else if (sum > {1'b0, PIX_MAX})      pix = PIX_MAX;
        else                                 pix = sum[PIX_W-1:0];
    end

    // output register payload
    always_ff @(posedge aclk) begin
        if (adv) begin
            out_reg.pixel_value  <= pix;
            out_reg.pixel_column <= job_reg.column_base + {{(POS_W - IDX_W - 1){1'b0}}, cnt_reg, 1'b0};
            out_reg.pixel_row    <= job_reg.row_index;
            out_reg.block_done   <= last;
        end
    end

    // working block and delta shifter
    always_ff @(posedge aclk) begin
        if (pop) begin
            job_reg   <= q_job;
            delta_reg <= q_job.deltas;
        end else if (adv && use_delta) begin
            delta_reg <= delta_reg >> DELTA_W;
        end
    end

    // control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg        <= '0;
            work_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            if (pop) begin
                cnt_reg        <= '0;
                work_valid_reg <= 1'b1;
            end else if (adv) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (last) work_valid_reg <= 1'b0;
            end
            if (adv)          out_valid_reg <= 1'b1;
            else if (m_ready) out_valid_reg <= 1'b0;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_word  = out_reg;

endmodule

`default_nettype wire

>>> src/raw_block_delta_decompressor_unit.sv
// top level: one 16-byte compressed block in, sixteen raw pixels out
// first pixel word passes the queue entry, the back end working block register and
//   its output register; later pixel words follow as the output accepts them
// throughput: one pixel per cycle from the back end output register when the output
//   is not stalled; a two-entry queue lets the front take blocks meanwhile
// reset: synchronous active-low aresetn clears column, row and queue, row width 4096
`default_nettype none

module raw_block_delta_decompressor_unit
    import rbdd_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               cfg_wr_en,
    input  wire logic [WIDTH_W-1:0] cfg_wr_data,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire in_word_t           s_word,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output out_word_t               m_word
);

    logic push, q_ready, q_valid, pop;
    job_t front_job, q_job;

    rbdd_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_word      (s_word),
        .push        (push),
        .q_ready     (q_ready),
        .job         (front_job)
    );

    rbdd_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .in_job    (front_job),
        .in_ready  (q_ready),
        .pop       (pop),
        .out_valid (q_valid),
        .out_job   (q_job)
    );

    rbdd_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_valid (q_valid),
        .q_job   (q_job),
        .pop     (pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_word  (m_word)
    );

endmodule

`default_nettype wire

>>> sim/tb_raw_block_delta_decompressor_unit.sv
// self-checking testbench for the block delta decompressor top level
`default_nettype none

module tb_raw_block_delta_decompressor_unit;
    import rbdd_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 2_000_000;
    localparam int MAX_REPORTS = 10;

    // decoder state mirror and queue of pixels still owed by the block
    class pixel_scoreboard;
        int unsigned row_width;
        int unsigned column_base;
        int unsigned row_index;
        out_word_t   pixels_due[$];
        int unsigned error_count;

        function new();
            row_width   = 4096;
            column_base = 0;
            row_index   = 0;
            error_count = 0;
        endfunction

        function void set_width(logic [WIDTH_W-1:0] value);
            row_width = value;
        endfunction

        // decode one accepted block word into its sixteen pixels, then advance
        function void add_block_pixels(in_word_t blk);
            logic [127:0] bits;
            logic [127:0] shifted;
            logic [10:0]  mx;
            logic [10:0]  mn;
            logic [3:0]   imax;
            logic [3:0]   imin;
            int unsigned  sh;
            int unsigned  pos;
            int unsigned  pix;
            int unsigned  lim;
            out_word_t    px;

            bits = {blk.block_high, blk.block_low};
            mx   = bits[10:0];
            mn   = bits[21:11];
            imax = bits[25:22];
            imin = bits[29:26];

            // shift from the spread; max below min keeps a zero shift
            sh = 0;
            if (mx >= mn) begin
                while (sh < 4 && (32'h80 << sh) <= int'(mx - mn)) sh++;
            end

            pos = 30;
            for (int i = 0; i < BLOCK_PIXELS; i++) begin
                if (i == imax) begin
                    pix = mx;
                end else if (i == imin) begin
                    pix = mn;
                end else begin
                    // bits past the top of the block shift in as zero
                    shifted = bits >> pos;
                    pix = (int'(shifted[6:0]) << sh) + int'(mn);
                    if (pix > 2047) pix = 2047;
                    pos += 7;
                end
                px.pixel_value  = pix[PIX_W-1:0];
                px.pixel_column = POS_W'(column_base + 2 * i);
                px.pixel_row    = POS_W'(row_index);
                px.block_done   = (i == BLOCK_PIXELS - 1);
                pixels_due.push_back(px);
            end

            // even base steps by one, odd base by 31, wrap to a new row
            lim = (row_width > MAX_ROW_WIDTH) ? MAX_ROW_WIDTH : row_width;
            column_base += column_base[0] ? 31 : 1;
            if (column_base + 30 >= lim) begin
                column_base = 0;
                row_index   = (row_index + 1) & 32'h3FFF;
            end
        endfunction

        // compare an accepted pixel word with the oldest one owed
        function void check_pixel(out_word_t got);
            out_word_t want;
            if (pixels_due.size() == 0) begin
                if (error_count < MAX_REPORTS)
                    $display("unexpected pixel word: value %0d column %0d row %0d done %0b",
                             got.pixel_value, got.pixel_column, got.pixel_row,
                             got.block_done);
                error_count++;
                return;
            end
            want = pixels_due.pop_front();
            if (got.pixel_value !== want.pixel_value ||
                got.pixel_column !== want.pixel_column ||
                got.pixel_row !== want.pixel_row ||
                got.block_done !== want.block_done) begin
                if (error_count < MAX_REPORTS)
                    $display({"pixel mismatch: value %0d/%0d column %0d/%0d ",
                              "row %0d/%0d done %0b/%0b (expected/actual)"},
                             want.pixel_value, got.pixel_value,
                             want.pixel_column, got.pixel_column,
                             want.pixel_row, got.pixel_row,
                             want.block_done, got.block_done);
                error_count++;
            end
        endfunction
    endclass

    logic               aclk;
    logic               aresetn;
    logic               cfg_wr_en;
    logic [WIDTH_W-1:0] cfg_wr_data;
    logic               s_valid;
    logic               s_ready;
    in_word_t           s_word;
    logic               m_valid;
    logic               m_ready;
    out_word_t          m_word;

    pixel_scoreboard sb;
    int              gap_pct;
    int              stall_pct;
    int              stall_left;
    int              cycle_count;

    // widths visited by the random phases, extremes and odd values included
    logic [WIDTH_W-1:0] width_plan [10] = '{
        15'd32, 15'd64, 15'd0, 15'd31, 15'd100,
        15'd16384, 15'd32767, 15'd1, 15'd4096, 15'd33
    };

    raw_block_delta_decompressor_unit u_top (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_word      (s_word),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_word      (m_word)
    );

    // 2 ns clock
    initial aclk = 1'b0;
    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // idle length: mostly none, some short, a few long
    function automatic int pick_gap(int pct);
        if ($urandom_range(0, 99) >= pct) return 0;
        if ($urandom_range(0, 9) == 0) return $urandom_range(10, 40);
        return $urandom_range(1, 3);
    endfunction

    function automatic logic [127:0] rand_bits();
        return {$urandom(), $urandom(), $urandom(), $urandom()};
    endfunction

    // delta bits come from the low 98 bits of the last argument
    function automatic in_word_t pack_block(logic [10:0] mx, logic [10:0] mn,
                                            logic [3:0] imax, logic [3:0] imin,
                                            logic [127:0] deltas);
        return in_word_t'({deltas[97:0], imin, imax, mn, mx});
    endfunction

    // random block: raw bits, a chosen spread, or a high minimum that clamps
    function automatic in_word_t rand_block();
        logic [127:0] r;
        int           imn;
        int           imx;
        logic [3:0]   pmin;
        r = rand_bits();
        case ($urandom_range(0, 2))
            0: return in_word_t'(r);
            1: begin
                imn = $urandom_range(0, 2047);
                imx = imn + $urandom_range(0, (1 << $urandom_range(6, 11)) - 1);
            end
            default: begin
                imn = $urandom_range(1800, 2047);
                imx = $urandom_range(0, 2047);
            end
        endcase
        if (imx > 2047) imx = 2047;
        pmin = ($urandom_range(0, 7) == 0) ? r[3:0] : r[7:4];
        return pack_block(imx[10:0], imn[10:0], r[3:0], pmin, r >> 30);
    endfunction

    // offer one block word and hold it until the block takes it
    task automatic send_block(input in_word_t blk);
        int gap;
        gap = pick_gap(gap_pct);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_word  <= blk;
        do @(posedge aclk); while (!s_ready);
        sb.add_block_pixels(blk);
    endtask

    // stop sending and let every owed pixel drain out
    task automatic finish_phase();
        s_valid <= 1'b0;
        while (sb.pixels_due.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_width(input logic [WIDTH_W-1:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        sb.set_width(value);
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
    endtask

    // result side back-pressure
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready    <= 1'b0;
            stall_left <= 0;
        end else if (stall_left != 0) begin
            m_ready    <= 1'b0;
            stall_left <= stall_left - 1;
        end else begin
            m_ready    <= 1'b1;
            stall_left <= pick_gap(stall_pct);
        end
    end

    // check every accepted pixel word
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) sb.check_pixel(m_word);
    end

    // run limit
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb_raw_block_delta_decompressor_unit: FAIL");
            $finish;
        end
    end

    initial begin
        in_word_t directed[$];

        aresetn     = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = '0;
        s_valid     = 1'b0;
        s_word      = '0;
        m_ready     = 1'b0;
        stall_left  = 0;
        cycle_count = 0;
        gap_pct     = 30;
        stall_pct   = 30;
        sb          = new();

        // corner blocks: all zero, all one, max below min
        directed.push_back(in_word_t'(128'd0));
        directed.push_back(in_word_t'({128{1'b1}}));
        directed.push_back(pack_block(11'd100, 11'd900, 4'd3, 4'd7, rand_bits()));
        // spreads on each side of every shift step
        directed.push_back(pack_block(11'd127, 11'd0, 4'd1, 4'd2, rand_bits()));
        directed.push_back(pack_block(11'd128, 11'd0, 4'd1, 4'd2, rand_bits()));
        directed.push_back(pack_block(11'd255, 11'd0, 4'd4, 4'd9, rand_bits()));
        directed.push_back(pack_block(11'd256, 11'd0, 4'd4, 4'd9, rand_bits()));
        directed.push_back(pack_block(11'd511, 11'd0, 4'd6, 4'd11, rand_bits()));
        directed.push_back(pack_block(11'd512, 11'd0, 4'd6, 4'd11, rand_bits()));
        directed.push_back(pack_block(11'd1023, 11'd0, 4'd8, 4'd13, rand_bits()));
        directed.push_back(pack_block(11'd1024, 11'd0, 4'd8, 4'd13, rand_bits()));
        directed.push_back(pack_block(11'd2047, 11'd0, 4'd10, 4'd14, rand_bits()));
        // sums above 2047 clamp, with small and large shifts
        directed.push_back(pack_block(11'd2047, 11'd2000, 4'd2, 4'd3, '1));
        directed.push_back(pack_block(11'd2047, 11'd1000, 4'd12, 4'd5, '1));
        // shared position: fifteen deltas, the last one past the block
        directed.push_back(pack_block(11'd300, 11'd200, 4'd5, 4'd5, '1));
        // positions at both ends
        directed.push_back(pack_block(11'd700, 11'd650, 4'd15, 4'd0, rand_bits()));
        directed.push_back(pack_block(11'd650, 11'd700, 4'd0, 4'd15, rand_bits()));
        // top bit alone and alternating patterns
        directed.push_back(in_word_t'({1'b1, 127'd0}));
        directed.push_back(in_word_t'({32{4'hA}}));
        directed.push_back(in_word_t'({32{4'h5}}));

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed part at the reset width
        foreach (directed[k]) send_block(directed[k]);
        finish_phase();

        // random phases, one width each, idling mixes varied per phase
        foreach (width_plan[p]) begin
            gap_pct   = ((p + 1) % 3) * 25;
            stall_pct = (p % 3) * 25;
            write_width(width_plan[p]);
            repeat (22) send_block(rand_block());
            finish_phase();
        end

        // full-rate run on a narrow row so rows wrap often
        gap_pct   = 0;
        stall_pct = 0;
        write_width(15'd64);
        repeat (30) send_block(rand_block());
        finish_phase();

        repeat (20) @(posedge aclk);
        if (sb.error_count == 0 && sb.pixels_due.size() == 0) begin
            $display("tb_raw_block_delta_decompressor_unit: PASS");
        end else begin
            $display("tb_raw_block_delta_decompressor_unit: FAIL");
        end
        $finish;
    end

endmodule

`default_nettype wire
